/* rtl/bf3_pkg.sv */
// ----------------------------------------------------------------------------
// bf3_pkg
// Shared constants and types of the 3x3 box filter stream unit.
// ----------------------------------------------------------------------------
package bf3_pkg;

   localparam int MAX_WIDTH    = 1024;
   localparam int COL_W        = $clog2(MAX_WIDTH);
   localparam int CNT_W        = COL_W + 1;
   localparam int HEIGHT_LIMIT = 1024;
   localparam int ROW_W        = 11;
   localparam int CFG_W        = 11;
   localparam int PIX_W        = 8;
   localparam int SUM_W        = 12;
   localparam int RECIP_W      = 12;
   localparam int RECIP_SHIFT  = 15;
   localparam logic [RECIP_W-1:0] RECIP_NINE = 12'd3641;

   typedef logic [PIX_W-1:0] pix_type;
   typedef logic [COL_W-1:0] col_type;

   typedef enum logic [0:0] {
      REG_FRAME_WIDTH  = 1'b0,
      REG_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic    en;
      col_type addr;
   } store_rd_type;

   typedef struct packed {
      logic    en;
      col_type addr;
      pix_type upper;
      pix_type middle;
   } store_wr_type;

endpackage

/* rtl/bf3_line_store.sv */
// ----------------------------------------------------------------------------
// bf3_line_store
// Upper and middle line memories, one read and one write per cycle, with a
// bypass for a write to the entry being read in the same cycle.
// ----------------------------------------------------------------------------
module bf3_line_store (
   input  logic                  clock,
   input  bf3_pkg::store_rd_type rd,
   input  bf3_pkg::store_wr_type wr,
   output bf3_pkg::pix_type      upper_q,
   output bf3_pkg::pix_type      middle_q
);

   bf3_pkg::pix_type upper_mem  [bf3_pkg::MAX_WIDTH];
   bf3_pkg::pix_type middle_mem [bf3_pkg::MAX_WIDTH];

   bf3_pkg::pix_type rd_upper_ff;
   bf3_pkg::pix_type rd_middle_ff;
   bf3_pkg::pix_type fwd_upper_ff;
   bf3_pkg::pix_type fwd_middle_ff;
   logic             fwd_hit_ff;
   logic             fwd_hit_in;

   assign fwd_hit_in = wr.en && (wr.addr == rd.addr);

   always_ff @(posedge clock) begin
      if (wr.en) begin
         upper_mem[wr.addr]  <= wr.upper;
         middle_mem[wr.addr] <= wr.middle;
      end
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_upper_ff   <= upper_mem[rd.addr];
         rd_middle_ff  <= middle_mem[rd.addr];
         fwd_hit_ff    <= fwd_hit_in;
         fwd_upper_ff  <= wr.upper;
         fwd_middle_ff <= wr.middle;
      end
   end

   assign upper_q  = fwd_hit_ff ? fwd_upper_ff  : rd_upper_ff;
   assign middle_q = fwd_hit_ff ? fwd_middle_ff : rd_middle_ff;

endmodule

/* rtl/box_filter_3x3_stream_unit.sv */
// ----------------------------------------------------------------------------
// box_filter_3x3_stream_unit
// Streaming 3x3 mean filter over 8-bit frames with zero-padded borders.
//
//   channel  dir  tdata          tlast    tuser
//   req_     in   pixel_in[7:0]  -        -
//   rsp_     out  mean_out[7:0]  row_end  frame_end
//   csr_     in   write enable, register index, write data (no read-back)
//
// One word per clock sustained while results are taken; a word passes stage 1 and the output register on its way out.
// Stage 0 reads both line memories, stage 1 writes them back and forms the
// mean, the output register parts the two sides.
// A result stall holds the output register; while it is full, stage 1 and
// the input hold as well.
// Reset is synchronous; line memories need no clearing, rows are masked.
// ----------------------------------------------------------------------------
module box_filter_3x3_stream_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [7:0]                 req_tdata,   // pixel_in[7:0]
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [7:0]                 rsp_tdata,   // mean_out[7:0]
   output logic                       rsp_tlast,
   output logic                       rsp_tuser,   // frame_end
   input  logic                       csr_we,
   input  logic                       csr_addr,
   input  logic [bf3_pkg::CFG_W-1:0]  csr_wdata
);

   localparam int CMP_W = bf3_pkg::ROW_W + 1;

   logic [bf3_pkg::CNT_W-1:0] width_ff,  width_in;
   logic [bf3_pkg::ROW_W-1:0] height_ff, height_in;
   bf3_pkg::col_type          col_ff,    col_in;
   logic [bf3_pkg::ROW_W-1:0] row_ff,    row_in;

   logic             s1_valid_ff,     s1_valid_in;
   bf3_pkg::col_type s1_col_ff,       s1_col_in;
   bf3_pkg::pix_type s1_bot_ff,       s1_bot_in;
   logic             s1_top_ok_ff,    s1_top_ok_in;
   logic             s1_mid_ok_ff,    s1_mid_ok_in;
   logic             s1_first_ff,     s1_first_in;
   logic             s1_emit_ff,      s1_emit_in;
   logic             s1_frame_end_ff, s1_frame_end_in;
   logic             s1_restart_ff,   s1_restart_in;

   logic             rsp_valid_ff,     rsp_valid_in;
   bf3_pkg::pix_type rsp_mean_ff,      rsp_mean_in;
   logic             rsp_row_end_ff,   rsp_row_end_in;
   logic             rsp_frame_end_ff, rsp_frame_end_in;

   bf3_pkg::pix_type win_ff [6];
   bf3_pkg::pix_type win_in [6];

   logic                  accept;
   logic                  commit;
   logic [CMP_W-1:0]      row_x;
   logic [CMP_W-1:0]      height_x;
   logic                  first_col;
   logic                  restart;
   logic [bf3_pkg::CNT_W-1:0] col_inc;

   bf3_pkg::store_rd_type st_rd;
   bf3_pkg::store_wr_type st_wr;
   bf3_pkg::pix_type      up_raw;
   bf3_pkg::pix_type      mid_raw;
   bf3_pkg::pix_type      top_m;
   bf3_pkg::pix_type      mid_m;

   logic [bf3_pkg::SUM_W-1:0]                 sum;
   logic [bf3_pkg::SUM_W+bf3_pkg::RECIP_W-1:0] prod;

   assign commit     = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || commit;
   assign accept     = req_tvalid && req_tready;

   assign row_x     = CMP_W'(row_ff);
   assign height_x  = CMP_W'(height_ff);
   assign first_col = (col_ff == '0);
   assign restart   = first_col && (row_x >= height_x + CMP_W'(1));
   assign col_inc   = bf3_pkg::CNT_W'(col_ff) + bf3_pkg::CNT_W'(1);

   // config registers and position counters
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      if (csr_we) begin
         case (bf3_pkg::csr_index_type'(csr_addr))
            bf3_pkg::REG_FRAME_WIDTH: begin
               if (csr_wdata == '0) begin
                  width_in = bf3_pkg::CNT_W'(1);
               end else if (32'(csr_wdata) > 32'(bf3_pkg::MAX_WIDTH)) begin
                  width_in = bf3_pkg::CNT_W'(bf3_pkg::MAX_WIDTH);
               end else begin
                  width_in = bf3_pkg::CNT_W'(csr_wdata);
               end
            end
            bf3_pkg::REG_FRAME_HEIGHT: begin
               if (csr_wdata == '0) begin
                  height_in = bf3_pkg::ROW_W'(1);
               end else if (32'(csr_wdata) > 32'(bf3_pkg::HEIGHT_LIMIT)) begin
                  height_in = bf3_pkg::ROW_W'(bf3_pkg::HEIGHT_LIMIT);
               end else begin
                  height_in = bf3_pkg::ROW_W'(csr_wdata);
               end
            end
            default: begin
            end
         endcase
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (restart) begin
            col_in = '0;
            row_in = '0;
         end else if (col_inc >= width_ff) begin
            col_in = '0;
            row_in = row_ff + bf3_pkg::ROW_W'(1);
         end else begin
            col_in = col_inc[bf3_pkg::COL_W-1:0];
         end
      end
   end

   // stage 0: classify the word and issue the line reads
   always_comb begin
      s1_valid_in     = s1_valid_ff;
      s1_col_in       = s1_col_ff;
      s1_bot_in       = s1_bot_ff;
      s1_top_ok_in    = s1_top_ok_ff;
      s1_mid_ok_in    = s1_mid_ok_ff;
      s1_first_in     = s1_first_ff;
      s1_emit_in      = s1_emit_ff;
      s1_frame_end_in = s1_frame_end_ff;
      s1_restart_in   = s1_restart_ff;
      if (commit) begin
         s1_valid_in = 1'b0;
      end
      if (accept) begin
         s1_valid_in     = 1'b1;
         s1_col_in       = col_ff;
         s1_bot_in       = (row_x < height_x) ? req_tdata : '0;
         s1_top_ok_in    = (row_x >= CMP_W'(2)) && (row_x < height_x + CMP_W'(2));
         s1_mid_ok_in    = (row_x >= CMP_W'(1)) && (row_x < height_x + CMP_W'(1));
         s1_first_in     = first_col;
         s1_emit_in      = first_col ? s1_top_ok_in : s1_mid_ok_in;
         s1_frame_end_in = first_col && (row_x == height_x + CMP_W'(1));
         s1_restart_in   = restart;
      end
   end

   assign st_rd.en   = accept;
   assign st_rd.addr = col_ff;

   assign st_wr.en     = commit;
   assign st_wr.addr   = s1_col_ff;
   assign st_wr.upper  = mid_raw;
   assign st_wr.middle = s1_bot_ff;

   bf3_line_store u_line_store (
      .clock    (clock),
      .rd       (st_rd),
      .wr       (st_wr),
      .upper_q  (up_raw),
      .middle_q (mid_raw)
   );

   // stage 1: mask, sum, divide by nine, advance the window
   assign top_m = s1_top_ok_ff ? up_raw  : '0;
   assign mid_m = s1_mid_ok_ff ? mid_raw : '0;

   always_comb begin
      sum = '0;
      for (int k = 0; k < 6; k++) begin
         sum = sum + bf3_pkg::SUM_W'(win_ff[k]);
      end
      if (!s1_first_ff) begin
         sum = sum + bf3_pkg::SUM_W'(top_m) + bf3_pkg::SUM_W'(mid_m)
               + bf3_pkg::SUM_W'(s1_bot_ff);
      end
   end

   assign prod = (bf3_pkg::SUM_W+bf3_pkg::RECIP_W)'(sum)
                 * (bf3_pkg::SUM_W+bf3_pkg::RECIP_W)'(bf3_pkg::RECIP_NINE);

   always_comb begin
      for (int k = 0; k < 6; k++) begin
         win_in[k] = win_ff[k];
      end
      if (csr_we) begin
         for (int k = 0; k < 6; k++) begin
            win_in[k] = '0;
         end
      end else if (commit) begin
         if (s1_restart_ff) begin
            for (int k = 0; k < 6; k++) begin
               win_in[k] = '0;
            end
         end else begin
            for (int k = 0; k < 3; k++) begin
               win_in[k] = s1_first_ff ? '0 : win_ff[k+3];
            end
            win_in[3] = top_m;
            win_in[4] = mid_m;
            win_in[5] = s1_bot_ff;
         end
      end
   end

   // output register
   always_comb begin
      rsp_valid_in     = rsp_valid_ff;
      rsp_mean_in      = rsp_mean_ff;
      rsp_row_end_in   = rsp_row_end_ff;
      rsp_frame_end_in = rsp_frame_end_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (commit && s1_emit_ff) begin
         rsp_valid_in     = 1'b1;
         rsp_mean_in      = prod[bf3_pkg::RECIP_SHIFT +: bf3_pkg::PIX_W];
         rsp_row_end_in   = s1_first_ff;
         rsp_frame_end_in = s1_frame_end_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= bf3_pkg::CNT_W'(bf3_pkg::MAX_WIDTH);
         height_ff    <= bf3_pkg::ROW_W'(bf3_pkg::HEIGHT_LIMIT);
         col_ff       <= '0;
         row_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < 6; k++) begin
            win_ff[k] <= '0;
         end
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int k = 0; k < 6; k++) begin
            win_ff[k] <= win_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_col_ff        <= s1_col_in;
      s1_bot_ff        <= s1_bot_in;
      s1_top_ok_ff     <= s1_top_ok_in;
      s1_mid_ok_ff     <= s1_mid_ok_in;
      s1_first_ff      <= s1_first_in;
      s1_emit_ff       <= s1_emit_in;
      s1_frame_end_ff  <= s1_frame_end_in;
      s1_restart_ff    <= s1_restart_in;
      rsp_mean_ff      <= rsp_mean_in;
      rsp_row_end_ff   <= rsp_row_end_in;
      rsp_frame_end_ff <= rsp_frame_end_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_mean_ff;
   assign rsp_tlast  = rsp_row_end_ff;
   assign rsp_tuser  = rsp_frame_end_ff;

   a_frame_end_is_row_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("frame end without row end");

   a_col_in_width: assert property (@(posedge clock) disable iff (reset)
      bf3_pkg::CNT_W'(col_ff) < width_ff)
      else $error("column counter beyond frame width");

   a_row_in_drain: assert property (@(posedge clock) disable iff (reset)
      row_x <= height_x + CMP_W'(1))
      else $error("row counter beyond drain rows");

   a_commit_frees_input: assert property (@(posedge clock) disable iff (reset)
      accept && s1_valid_ff |-> commit)
      else $error("word accepted while stage 1 held");

endmodule

/* tb/box_mean_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// box_mean_checker
// Watches the pixel, result and register ports of the 3x3 box filter. Keeps
// its own line stores, window and frame position, predicts the mean word for
// each accepted pixel word that yields a result and compares each result word,
// field by field, with the oldest prediction still waiting. Reports the
// mismatch count and the number of predictions not yet matched.
// ----------------------------------------------------------------------------
module box_mean_checker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   input  logic                      req_tready,
   input  logic [7:0]                req_tdata,   // pixel_in[7:0]
   input  logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  logic [7:0]                rsp_tdata,   // mean_out[7:0]
   input  logic                      rsp_tlast,
   input  logic                      rsp_tuser,   // frame_end
   input  logic                      csr_we,
   input  logic                      csr_addr,
   input  logic [bf3_pkg::CFG_W-1:0] csr_wdata,
   output int                        pending_count,
   output int                        error_count
);

   localparam int BOX_AREA = 9;

   typedef struct packed {
      bf3_pkg::pix_type mean_out;
      logic             row_end;
      logic             frame_end;
   } mean_word_type;

   mean_word_type                 expected_means[$];
   bf3_pkg::pix_type              upper_line[bf3_pkg::MAX_WIDTH];
   bf3_pkg::pix_type              middle_line[bf3_pkg::MAX_WIDTH];
   bf3_pkg::pix_type              window_px[6];
   logic [bf3_pkg::CFG_W-1:0]     width_reg;
   logic [bf3_pkg::CFG_W-1:0]     height_reg;
   logic [bf3_pkg::CNT_W-1:0]     col_pos;
   logic [bf3_pkg::ROW_W-1:0]     row_pos;
   int                            mismatches = 0;

   assign error_count = mismatches;

   function automatic int clamp_dim(input logic [bf3_pkg::CFG_W-1:0] value,
                                    input int limit);
      if (value == 0) return 1;
      if (value > limit) return limit;
      return value;
   endfunction

   task restart_frame();
      foreach (window_px[k]) window_px[k] = '0;
      col_pos = '0;
      row_pos = '0;
   endtask

   task predict_mean(input bf3_pkg::pix_type pixel, output bit emit,
                     output mean_word_type word);
      int                        w;
      int                        h;
      int                        ci;
      int                        ri;
      int                        col;
      bf3_pkg::pix_type          top;
      bf3_pkg::pix_type          mid;
      bf3_pkg::pix_type          bot;
      logic [bf3_pkg::SUM_W-1:0] sum;
      w    = clamp_dim(width_reg, bf3_pkg::MAX_WIDTH);
      h    = clamp_dim(height_reg, bf3_pkg::HEIGHT_LIMIT);
      ci   = col_pos;
      ri   = row_pos;
      col  = (ci < bf3_pkg::MAX_WIDTH) ? ci : 0;
      emit = 1'b0;
      word = '0;

      // mask rows above and below the frame
      top = (ri >= 2 && ri - 2 < h) ? upper_line[col] : '0;
      mid = (ri >= 1 && ri - 1 < h) ? middle_line[col] : '0;
      bot = (ri < h) ? pixel : '0;
      upper_line[col]  = middle_line[col];
      middle_line[col] = bot;

      sum = '0;
      foreach (window_px[k]) sum += window_px[k];

      if (ci == 0) begin
         if (ri >= 2 && ri - 2 < h) begin
            emit           = 1'b1;
            word.mean_out  = bf3_pkg::pix_type'(sum / BOX_AREA);
            word.row_end   = 1'b1;
            word.frame_end = (ri - 2 == h - 1);
         end
         window_px[0] = '0;
         window_px[1] = '0;
         window_px[2] = '0;
      end else begin
         if (ri >= 1 && ri - 1 < h) begin
            sum += top + mid + bot;
            emit           = 1'b1;
            word.mean_out  = bf3_pkg::pix_type'(sum / BOX_AREA);
            word.row_end   = 1'b0;
            word.frame_end = 1'b0;
         end
         window_px[0] = window_px[3];
         window_px[1] = window_px[4];
         window_px[2] = window_px[5];
      end
      window_px[3] = top;
      window_px[4] = mid;
      window_px[5] = bot;

      if (ci == 0 && ri >= h + 1) begin
         restart_frame();
      end else begin
         ci++;
         if (ci >= w) begin
            ci = 0;
            ri++;
         end
         col_pos = bf3_pkg::CNT_W'(ci);
         row_pos = bf3_pkg::ROW_W'(ri);
      end
   endtask

   always @(posedge clock) begin
      mean_word_type want;
      mean_word_type got;
      bit            emit;
      if (reset) begin
         width_reg  = bf3_pkg::CFG_W'(bf3_pkg::MAX_WIDTH);
         height_reg = bf3_pkg::CFG_W'(bf3_pkg::HEIGHT_LIMIT);
         foreach (upper_line[i]) begin
            upper_line[i]  = '0;
            middle_line[i] = '0;
         end
         restart_frame();
         expected_means.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata, rsp_tlast, rsp_tuser};
            if (expected_means.size() == 0) begin
               $error("result word with nothing expected: mean_out %0d, row_end %0d, frame_end %0d",
                      got.mean_out, got.row_end, got.frame_end);
               mismatches++;
            end else begin
               want = expected_means.pop_front();
               if (got.mean_out !== want.mean_out) begin
                  $error("mean_out: expected %0d, actual %0d", want.mean_out, got.mean_out);
                  mismatches++;
               end
               if (got.row_end !== want.row_end) begin
                  $error("row_end: expected %0d, actual %0d", want.row_end, got.row_end);
                  mismatches++;
               end
               if (got.frame_end !== want.frame_end) begin
                  $error("frame_end: expected %0d, actual %0d", want.frame_end, got.frame_end);
                  mismatches++;
               end
            end
         end
         if (csr_we) begin
            case (bf3_pkg::csr_index_type'(csr_addr))
               bf3_pkg::REG_FRAME_WIDTH:  width_reg  = csr_wdata;
               bf3_pkg::REG_FRAME_HEIGHT: height_reg = csr_wdata;
               default: begin
               end
            endcase
            restart_frame();
         end
         if (req_tvalid && req_tready) begin
            predict_mean(req_tdata, emit, want);
            if (emit) expected_means.push_back(want);
         end
      end
      pending_count <= expected_means.size();
   end

endmodule

/* tb/tb_box_filter_3x3_stream_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_box_filter_3x3_stream_unit
// Streams frames of pixel words through the 3x3 box filter under a range of
// frame sizes, including the reset size, zero and oversized registers and
// frames cut short by a register write. Both sides idle at random; one phase
// holds off the result side for a long stretch, others pause the pixel side
// until all results are in. Checking is left to the box_mean_checker.
// ----------------------------------------------------------------------------
module tb_box_filter_3x3_stream_unit;

   localparam int CLOCK_HALF    = 6;
   localparam int RESET_CYCLES  = 6;
   localparam int LONG_HOLD     = 300;
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_WORDS  = 450;
   localparam int CYCLE_LIMIT   = 1_000_000;

   typedef enum int {
      FILL_RANDOM,
      FILL_ZERO,
      FILL_MAX,
      FILL_SPLIT
   } fill_mode_type;

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [7:0]                req_tdata  = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [7:0]                rsp_tdata;
   logic                      rsp_tlast;
   logic                      rsp_tuser;
   logic                      csr_we     = 1'b0;
   logic                      csr_addr   = 1'b0;
   logic [bf3_pkg::CFG_W-1:0] csr_wdata  = '0;

   int pending_count;
   int error_count;
   bit no_idle       = 1'b0;
   int hold_requests = 0;
   int words_sent    = 0;
   int cycle_count   = 0;

   box_filter_3x3_stream_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   box_mean_checker u_mean_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .rsp_tuser     (rsp_tuser),
      .csr_we        (csr_we),
      .csr_addr      (csr_addr),
      .csr_wdata     (csr_wdata),
      .pending_count (pending_count),
      .error_count   (error_count)
   );

   initial begin
      forever #CLOCK_HALF clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Verification failed");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic bf3_pkg::pix_type pick_pixel(input fill_mode_type fill);
      case (fill)
         FILL_ZERO:  return '0;
         FILL_MAX:   return '1;
         FILL_SPLIT: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
         default:    return bf3_pkg::pix_type'($urandom_range(0, 255));
      endcase
   endfunction

   // result side: random stalls, plus a long hold-off on request
   initial begin
      int served;
      int lo;
      served = 0;
      forever begin
         @(posedge clock);
         if (hold_requests != served) begin
            served = hold_requests;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         lo = pick_gap();
         if (lo > 0) begin
            rsp_tready <= 1'b0;
            repeat (lo) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   task automatic write_reg(input bf3_pkg::csr_index_type idx,
                            input logic [bf3_pkg::CFG_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic send_word(input bf3_pkg::pix_type pixel);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pixel;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      words_sent++;
   endtask

   // drop valid and hold until every predicted result word has come back
   task automatic wait_idle(input int settle);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic run_phase(input logic [bf3_pkg::CFG_W-1:0] w_cfg,
                            input logic [bf3_pkg::CFG_W-1:0] h_cfg,
                            input int frames, input int cut, input fill_mode_type fill,
                            input bit write_cfg, input bit pause);
      int w;
      int h;
      int total;
      int pause_at;
      w = (w_cfg == 0) ? 1 :
          ((w_cfg > bf3_pkg::MAX_WIDTH) ? bf3_pkg::MAX_WIDTH : int'(w_cfg));
      h = (h_cfg == 0) ? 1 :
          ((h_cfg > bf3_pkg::HEIGHT_LIMIT) ? bf3_pkg::HEIGHT_LIMIT : int'(h_cfg));
      total = frames * (w * (h + 1) + 1);
      if (cut < 0) total = $urandom_range(1, total - 1);
      else if (cut > 0 && cut < total) total = cut;
      pause_at = pause ? total / 2 : -1;
      if (write_cfg) begin
         write_reg(bf3_pkg::REG_FRAME_WIDTH, w_cfg);
         write_reg(bf3_pkg::REG_FRAME_HEIGHT, h_cfg);
      end
      for (int i = 0; i < total; i++) begin
         if (i == pause_at) wait_idle(0);
         send_word(pick_pixel(fill));
      end
      wait_idle(SETTLE_CYCLES);
   endtask

   initial begin
      int                        start;
      int                        phase;
      int                        r;
      int                        frames;
      int                        cut;
      bit                        pause;
      logic [bf3_pkg::CFG_W-1:0] w_cfg;
      logic [bf3_pkg::CFG_W-1:0] h_cfg;
      fill_mode_type             fill;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset frame size, first row only: nothing may come out
      run_phase(bf3_pkg::CFG_W'(1024), bf3_pkg::CFG_W'(1024), 1, 100, FILL_RANDOM,
                1'b0, 1'b0);

      run_phase(bf3_pkg::CFG_W'(1), bf3_pkg::CFG_W'(1), 1, 0, FILL_MAX, 1'b1, 1'b0);
      run_phase(bf3_pkg::CFG_W'(0), bf3_pkg::CFG_W'(0), 1, 0, FILL_ZERO, 1'b1, 1'b0);
      run_phase(bf3_pkg::CFG_W'(3), bf3_pkg::CFG_W'(2), 1, 0, FILL_MAX, 1'b1, 1'b0);
      run_phase(bf3_pkg::CFG_W'(4), bf3_pkg::CFG_W'(3), 1, 5, FILL_RANDOM, 1'b1, 1'b0);
      run_phase(bf3_pkg::CFG_W'(2), bf3_pkg::CFG_W'(1), 1, 0, FILL_SPLIT, 1'b1, 1'b0);

      run_phase(bf3_pkg::CFG_W'(2047), bf3_pkg::CFG_W'(0), 1, 40, FILL_RANDOM,
                1'b1, 1'b0);
      run_phase(bf3_pkg::CFG_W'(0), bf3_pkg::CFG_W'(2047), 1, 60, FILL_RANDOM,
                1'b1, 1'b0);

      start = words_sent;
      phase = 0;
      while (words_sent - start < RANDOM_WORDS) begin
         r = $urandom_range(0, 99);
         if (r < 70) w_cfg = bf3_pkg::CFG_W'($urandom_range(1, 8));
         else if (r < 95) w_cfg = bf3_pkg::CFG_W'($urandom_range(9, 24));
         else w_cfg = bf3_pkg::CFG_W'($urandom_range(25, 40));
         h_cfg  = bf3_pkg::CFG_W'($urandom_range(1, 6));
         frames = $urandom_range(1, 2);
         cut    = ($urandom_range(0, 4) == 0) ? -1 : 0;
         r = $urandom_range(0, 99);
         if (r < 85) fill = FILL_RANDOM;
         else if (r < 90) fill = FILL_ZERO;
         else if (r < 95) fill = FILL_MAX;
         else fill = FILL_SPLIT;
         pause = (phase == 1 || phase == 4);
         if (phase == 0) begin
            w_cfg         = bf3_pkg::CFG_W'(24);
            h_cfg         = bf3_pkg::CFG_W'(4);
            frames        = 1;
            cut           = 0;
            no_idle       <= 1'b1;
            hold_requests <= hold_requests + 1;
         end else begin
            no_idle <= ($urandom_range(0, 5) == 0);
         end
         run_phase(w_cfg, h_cfg, frames, cut, fill, 1'b1, pause);
         phase++;
      end

      if (error_count == 0 && pending_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/bf3_pkg.sv
rtl/bf3_line_store.sv
rtl/box_filter_3x3_stream_unit.sv
tb/box_mean_checker.sv
tb/tb_box_filter_3x3_stream_unit.sv
